[design/apq_pkg.sv]
// Shared types, codes and constants of the array priority queue.
`default_nettype none

package apq_pkg;

    localparam int APQ_CAPACITY = 64;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 7;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CLOSE,
        S_DONE
    } apq_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_ROTATE,
        CELL_CLOSE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  priority_val;
    } cell_cmd_t;

endpackage

`default_nettype wire

[design/array_priority_queue.sv]
// Top level of the array priority queue: a ring of storage cells under one sequencer.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tdata: func, value_in, priority_in
//  m_*      | out       | m_tvalid/m_tready  | m_tdata: status, value_out, entry_count
//
//  Insert, overflow and underflow go from accept straight to the done state, from
//  which the result register loads as soon as it is free.
//  Successful delete: the scan rotates the whole cell ring once past the single
//  comparator at cell 0, then the close state shuts the gap, and the result register
//  loads from the done state.
//  aresetn (synchronous, active low) empties the queue; cell contents are not cleared.
//  A new transaction is taken while a previous result still waits on m_tready;
//  a finished result holds in the sequencer until the output register frees up.
`default_nettype none

module array_priority_queue #(
    parameter int CAPACITY = apq_pkg::APQ_CAPACITY
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [0] func, [32:1] value_in, [64:33] priority_in, [71:65] zero
    input  wire [71:0]  s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [1:0] status, [33:2] value_out, [40:34] entry_count, [47:41] zero
    output logic [47:0] m_tdata
);
    import apq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // unpack the request fields
    logic                     func;
    logic signed [DATA_W-1:0] value_in;
    logic signed [DATA_W-1:0] priority_in;

    assign func        = s_tdata[0];
    assign value_in    = s_tdata[DATA_W:1];
    assign priority_in = s_tdata[2*DATA_W:DATA_W+1];

    cell_cmd_t                cmd;
    logic [IDX_W-1:0]         target;
    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic signed [DATA_W-1:0] cell_prio  [CAPACITY];

    logic [STATUS_W-1:0]      m_status;
    logic signed [DATA_W-1:0] m_value;
    logic [CNT_W-1:0]         m_count;
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

    // ring of cells: each takes from its right neighbor; the last wraps to cell 0
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        apq_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .target      (target),
            .right_value (cell_value[(i + 1) % CAPACITY]),
            .right_prio  (cell_prio[(i + 1) % CAPACITY]),
            .value       (cell_value[i]),
            .prio        (cell_prio[i])
        );
    end

    // sequencer: decode, scan the head of the ring, keep count and results
    apq_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .func        (func),
        .value_in    (value_in),
        .priority_in (priority_in),
        .head_value  (cell_value[0]),
        .head_prio   (cell_prio[0]),
        .cmd         (cmd),
        .target      (target),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_status    (m_status),
        .m_value     (m_value),
        .m_count     (m_count)
    );

    // entry_count carries the low bits of the held count
    assign count_wide = {{COUNT_OUT_W{1'b0}}, m_count};
    assign m_tdata    = {7'd0, count_wide[COUNT_OUT_W-1:0], m_value, m_status};

endmodule

`default_nettype wire

[design/apq_cell.sv]
// One storage cell of the queue: holds a value/priority pair and trades with its neighbor.
`default_nettype none

module apq_cell #(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  wire                                 aclk,
    input  apq_pkg::cell_cmd_t                  cmd,
    input  wire [IDX_W-1:0]                     target,
    input  wire signed [apq_pkg::DATA_W-1:0]    right_value,
    input  wire signed [apq_pkg::DATA_W-1:0]    right_prio,
    output logic signed [apq_pkg::DATA_W-1:0]   value,
    output logic signed [apq_pkg::DATA_W-1:0]   prio
);
    import apq_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] prio_reg;
    logic signed [DATA_W-1:0] value_next;
    logic signed [DATA_W-1:0] prio_next;

    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        case (cmd.op)
            CELL_LOAD: begin
                if (target == MY_IDX) begin
                    value_next = cmd.value;
                    prio_next  = cmd.priority_val;
                end
            end
            CELL_ROTATE: begin
                value_next = right_value;
                prio_next  = right_prio;
            end
            CELL_CLOSE: begin
                // shift down over the removed slot
                if (MY_IDX >= target) begin
                    value_next = right_value;
                    prio_next  = right_prio;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

`default_nettype wire

[design/apq_ctrl.sv]
// Sequencer of the queue: request decode, head scan for the maximum, count and result register.
`default_nettype none

module apq_ctrl #(
    parameter int CAPACITY = apq_pkg::APQ_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire                                 func,
    input  wire signed [apq_pkg::DATA_W-1:0]    value_in,
    input  wire signed [apq_pkg::DATA_W-1:0]    priority_in,
    input  wire signed [apq_pkg::DATA_W-1:0]    head_value,
    input  wire signed [apq_pkg::DATA_W-1:0]    head_prio,
    output apq_pkg::cell_cmd_t                  cmd,
    output logic [IDX_W-1:0]                    target,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [apq_pkg::STATUS_W-1:0]        m_status,
    output logic signed [apq_pkg::DATA_W-1:0]   m_value,
    output logic [CNT_W-1:0]                    m_count
);
    import apq_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    apq_state_t state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          step_reg, step_next;
    logic [IDX_W-1:0]          best_idx_reg, best_idx_next;
    logic signed [DATA_W-1:0]  best_prio_reg, best_prio_next;
    logic signed [DATA_W-1:0]  best_value_reg, best_value_next;
    logic [STATUS_W-1:0]       res_status_reg, res_status_next;
    logic signed [DATA_W-1:0]  res_value_reg, res_value_next;
    logic                      m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]       m_status_reg, m_status_next;
    logic signed [DATA_W-1:0]  m_value_reg, m_value_next;
    logic [CNT_W-1:0]          m_count_reg, m_count_next;
    logic                      accept;
    logic                      in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg       <= step_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_value_reg <= best_value_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_count_reg    <= m_count_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_range = (CNT_W'(step_reg) < count_reg);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        step_next        = step_reg;
        best_idx_next    = best_idx_reg;
        best_prio_next   = best_prio_reg;
        best_value_next  = best_value_reg;
        res_status_next  = res_status_reg;
        res_value_next   = res_value_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_value_next     = m_value_reg;
        m_count_next     = m_count_reg;
        cmd.op           = CELL_HOLD;
        cmd.value        = value_in;
        cmd.priority_val = priority_in;
        target           = count_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_value_next = '0;
                    state_next     = S_DONE;
                    if (func == FUNC_INSERT) begin
                        if (count_reg == FULL_CNT) begin
                            res_status_next = ST_OVERFLOW;
                        end else begin
                            cmd.op          = CELL_LOAD;
                            count_next      = count_reg + 1'b1;
                            res_status_next = ST_INSERTED;
                        end
                    end else if (count_reg == '0) begin
                        res_status_next = ST_UNDERFLOW;
                    end else begin
                        step_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // cell 0 holds entry step_reg; strict compare keeps the earliest tie
                cmd.op = CELL_ROTATE;
                if (in_range && (step_reg == '0 || head_prio > best_prio_reg)) begin
                    best_idx_next   = step_reg;
                    best_prio_next  = head_prio;
                    best_value_next = head_value;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_IDX) begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE: begin
                cmd.op          = CELL_CLOSE;
                target          = best_idx_reg;
                count_next      = count_reg - 1'b1;
                res_status_next = ST_REMOVED;
                res_value_next  = best_value_reg;
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_count_next  = count_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_value  = m_value_reg;
    assign m_count  = m_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count above capacity");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && step_reg == LAST_IDX) |=> (state_reg == S_CLOSE))
        else $error("scan did not hand over to gap closing");

    a_close_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLOSE) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("removal did not decrement count");

    a_empty_delete: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && func == FUNC_DELETE && count_reg == '0)
            |=> (state_reg == S_DONE && res_status_reg == ST_UNDERFLOW))
        else $error("delete on empty queue not reported as underflow");

endmodule

`default_nettype wire

[bench/apq_scoreboard_pkg.sv]
// Scoreboard for the array priority queue bench: queue predictor and result checker.
package apq_scoreboard_pkg;

    import apq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [DATA_W-1:0]      value;
        logic [COUNT_OUT_W-1:0] count;
    } queue_result_t;

    class queue_scoreboard;
        logic [DATA_W-1:0]        held_value[$];
        logic signed [DATA_W-1:0] held_prio[$];
        queue_result_t            awaited[$];
        int                       capacity;
        int                       errors;

        function new(int cap);
            capacity = cap;
            errors   = 0;
        endfunction

        // Print one line per mismatch and count it.
        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        // Apply an accepted request to the shadow queue and queue the result it causes.
        function void note_request(logic func, logic [DATA_W-1:0] v,
                                   logic signed [DATA_W-1:0] p);
            queue_result_t r;
            int            best;
            r.value = '0;
            if (func == FUNC_INSERT) begin
                if (held_value.size() >= capacity) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    held_value.push_back(v);
                    held_prio.push_back(p);
                    r.status = ST_INSERTED;
                end
            end else if (held_value.size() == 0) begin
                r.status = ST_UNDERFLOW;
            end else begin
                // strict greater-than keeps the earliest arrival on ties
                best = 0;
                for (int i = 1; i < held_prio.size(); i++) begin
                    if (held_prio[i] > held_prio[best]) begin
                        best = i;
                    end
                end
                r.value = held_value[best];
                held_value.delete(best);
                held_prio.delete(best);
                r.status = ST_REMOVED;
            end
            r.count = COUNT_OUT_W'(held_value.size());
            awaited.push_back(r);
        endfunction

        // Compare one accepted result with the oldest outstanding expectation.
        task check_result(logic [47:0] d);
            queue_result_t want;
            logic [STATUS_W-1:0]    got_status;
            logic [DATA_W-1:0]      got_value;
            logic [COUNT_OUT_W-1:0] got_count;
            got_status = d[1:0];
            got_value  = d[33:2];
            got_count  = d[40:34];
            if (awaited.size() == 0) begin
                report($sformatf("result with nothing outstanding, tdata=%h", d));
                return;
            end
            want = awaited.pop_front();
            if (got_status != want.status) begin
                report($sformatf("status %0d, expected %0d", got_status, want.status));
            end
            if (got_value != want.value) begin
                report($sformatf("value_out %h, expected %h", got_value, want.value));
            end
            if (got_count != want.count) begin
                report($sformatf("entry_count %0d, expected %0d", got_count, want.count));
            end
        endtask

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

endpackage

[bench/tb.sv]
// Top-level bench for the array priority queue: stream drivers, monitor and watchdog.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import apq_pkg::*;
    import apq_scoreboard_pkg::*;

    localparam int CAPACITY      = APQ_CAPACITY;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int HOLD_CYCLES   = 600;             // long receiver back-pressure
    localparam int HOLD_AFTER    = 250;             // transactions before the long hold
    localparam int QUIET_LIMIT   = 4000;            // cycles with no transaction at all
    localparam int DRAIN_CYCLES  = 2 * CAPACITY + 20;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // [0] func, [32:1] value_in, [64:33] priority_in, [71:65] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // [1:0] status, [33:2] value_out, [40:34] entry_count

    queue_scoreboard board;
    int  requests_taken = 0;
    int  burst_left;
    bit  offering = 1'b0;
    bit  long_hold_done = 1'b0;
    int  quiet_cycles = 0;

    array_priority_queue #(.CAPACITY(CAPACITY)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mix narrow priorities (many ties), the signed extremes and fully random ones.
    function automatic logic [DATA_W-1:0] pick_prio();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return DATA_W'(int'($urandom_range(0, 6)) - 3);
            4: return 32'h8000_0000;
            5: return 32'h7fff_ffff;
            6: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request and hold it until the block takes it; close the burst with a gap
    // when it runs out so that idle cycles land on every phase of the sequencer.
    task automatic issue(input logic func, input logic [DATA_W-1:0] v,
                         input logic [DATA_W-1:0] p);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, p, v, func};
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_request(func, v, p);
        requests_taken++;
        burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // Main stimulus: reset, directed corner cases, then random segments.
    initial begin
        int sent;
        int seg_len;
        int insert_pct;
        logic func;
        board    = new(CAPACITY);
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        burst_left = $urandom_range(1, 20);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Drain an empty queue, then add both signed extremes, with a tie at the top.
        issue(FUNC_DELETE, $urandom, $urandom);
        issue(FUNC_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
        issue(FUNC_INSERT, 32'h8000_0000, 32'h8000_0000);
        issue(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000);
        issue(FUNC_INSERT, 32'hffff_ffff, 32'hffff_ffff);
        issue(FUNC_INSERT, 32'h0000_0005, 32'h0000_0000);
        issue(FUNC_INSERT, 32'ha5a5_a5a5, 32'h7fff_ffff);
        issue(FUNC_INSERT, 32'h5a5a_5a5a, 32'h0000_0001);
        // Empty it completely and once more past empty.
        repeat (8) issue(FUNC_DELETE, $urandom, $urandom);
        // Equal negative priorities interleaved with deletes.
        issue(FUNC_INSERT, 32'h0000_0001, 32'hffff_fffe);
        issue(FUNC_INSERT, 32'h0000_0002, 32'hffff_fffe);
        issue(FUNC_DELETE, 32'hffff_ffff, 32'hffff_ffff);
        issue(FUNC_INSERT, 32'h0000_0003, 32'h0000_0005);
        issue(FUNC_DELETE, '0, '0);
        issue(FUNC_DELETE, $urandom, $urandom);

        // Fill past capacity so the overflow path shows up early.
        sent = 0;
        repeat (CAPACITY + 6) begin
            issue(FUNC_INSERT, $urandom, pick_prio());
            sent++;
        end

        // Segments biased toward filling, churning or draining the queue.
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0: insert_pct = 90;
                1: insert_pct = 50;
                default: insert_pct = 15;
            endcase
            seg_len = $urandom_range(20, 150);
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
                func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_DELETE;
                issue(func, $urandom, pick_prio());
                sent++;
            end
        end

        if (offering) begin
            s_tvalid <= 1'b0;
        end
        // Wait out every outstanding result, then watch for strays.
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver: switch among stall patterns, with one long hold-off to fill the block.
    initial begin
        int mode;
        int mode_left;
        int phase;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!long_hold_done && requests_taken >= HOLD_AFTER) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((phase % 7) < 4);
                endcase
            end
        end
    end

    // Check every result transaction at the edge that accepts it.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
        end
    end

    // End the run when no transaction moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
